### rtl/mpe_pkg.sv
// ----------------------------------------------------------------------------
// Midpoint ellipse package
// Shared constants and types for the midpoint ellipse point generator.
// ----------------------------------------------------------------------------
package mpe_pkg;

    // Width of a plotted coordinate, two's complement
    localparam int PIX_W = 13;

    // Control word of the shared multiply/add unit
    typedef struct packed {
        logic mul_en;   // capture a new product this cycle
        logic sub;      // adder computes opa - opb instead of opa + opb
    } alu_ctl_t;

endpackage

### rtl/midpoint_ellipse_point_generator.sv
// ----------------------------------------------------------------------------
// Midpoint ellipse point generator
// A start squares both radii and forms the first decision value; a step
// updates slopes and decision, and entering region 2 recomputes the decision.
// One shared multiplier and one shared adder are stepped by the sequencer;
// s_ready is high only while the sequencer is idle. Four points follow at
// one per cycle while m_ready is high and overlap the next item's work.
// Synchronous active-low reset returns to idle with no ellipse in progress.
// ----------------------------------------------------------------------------
module midpoint_ellipse_point_generator #(
    parameter int RADIUS_BITS = 10,
    parameter int COORD_BITS  = 11
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_operation,
    input  logic [COORD_BITS-1:0]              s_center_x,
    input  logic [COORD_BITS-1:0]              s_center_y,
    input  logic [RADIUS_BITS-1:0]             s_radius_x,
    input  logic [RADIUS_BITS-1:0]             s_radius_y,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [mpe_pkg::PIX_W-1:0]   m_pixel_x,
    output logic signed [mpe_pkg::PIX_W-1:0]   m_pixel_y,
    output logic                               m_last_of_group,
    output logic                               m_finished
);
    import mpe_pkg::*;

    localparam int SQ_W    = 2 * RADIUS_BITS;
    localparam int OFS_W   = RADIUS_BITS + 1;
    localparam int MUL_W   = 2 * RADIUS_BITS + 2;
    localparam int SLOPE_W = 3 * RADIUS_BITS + 3;
    localparam int DEC_W   = 4 * RADIUS_BITS + 8;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_REG1 = 4'b0010,
        PH_REG2 = 4'b0100,
        PH_DONE = 4'b1000
    } phase_t;

    typedef enum logic [20:0] {
        S_IDLE   = 21'h000001,
        S_SQ_RX  = 21'h000002,
        S_SQ_RY  = 21'h000004,
        S_RXRY   = 21'h000008,
        S_YS     = 21'h000010,
        S_DEC0   = 21'h000020,
        S_QTR    = 21'h000040,
        S_SETTLE = 21'h000080,
        S_RC0    = 21'h000100,
        S_RC1    = 21'h000200,
        S_RC2    = 21'h000400,
        S_RC3    = 21'h000800,
        S_RC4    = 21'h001000,
        S_RC5    = 21'h002000,
        S_RC6    = 21'h004000,
        S_ST_X   = 21'h008000,
        S_ST_Y   = 21'h010000,
        S_ST_DA  = 21'h020000,
        S_ST_DX  = 21'h040000,
        S_ST_DY  = 21'h080000,
        S_EMIT   = 21'h100000
    } state_t;

    state_t                   state_reg, state_next;
    phase_t                   phase_reg, phase_next;

    logic [COORD_BITS-1:0]    cx_reg, cx_next;
    logic [COORD_BITS-1:0]    cy_reg, cy_next;
    logic [RADIUS_BITS-1:0]   rx_reg, rx_next;
    logic [RADIUS_BITS-1:0]   ry_reg, ry_next;
    logic [OFS_W-1:0]         x_reg, x_next;
    logic [RADIUS_BITS-1:0]   y_reg, y_next;
    logic [SQ_W-1:0]          rx_sq_reg, rx_sq_next;
    logic [SQ_W-1:0]          ry_sq_reg, ry_sq_next;
    logic [SLOPE_W-1:0]       xs_reg, xs_next;
    logic [SLOPE_W-1:0]       ys_reg, ys_next;
    logic signed [DEC_W-1:0]  dec_reg, dec_next;
    logic                     diag_reg, diag_next;
    logic                     fin_reg, fin_next;

    alu_ctl_t                 alu_ctl;
    logic [MUL_W-1:0]         mul_a, mul_b;
    logic signed [DEC_W-1:0]  opa, opb;
    logic [2*MUL_W-1:0]       prod;
    logic signed [DEC_W-1:0]  sum;

    logic                     emit_load;
    logic                     emit_busy;
    logic                     in_reg1, in_reg2;
    logic                     move_x, move_y;
    logic [RADIUS_BITS-1:0]   ty_abs;
    logic                     qtr_round;

    assign in_reg1 = (phase_reg == PH_REG1);
    assign in_reg2 = (phase_reg == PH_REG2);
    // Region 1 always moves x, region 2 always moves y; diagonal moves both
    assign move_x  = in_reg1 || diag_reg;
    assign move_y  = in_reg2 || diag_reg;
    // |offset_y - 1|, offset_y never below zero
    assign ty_abs  = (y_reg == '0) ? RADIUS_BITS'(1) : (y_reg - RADIUS_BITS'(1));
    // Round a negative quarter value toward zero
    assign qtr_round = dec_reg[DEC_W-1] && (dec_reg[1:0] != 2'b00);

    assign s_ready = (state_reg == S_IDLE);

    // Sequencer and datapath register updates
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        rx_sq_next = rx_sq_reg;
        ry_sq_next = ry_sq_reg;
        xs_next    = xs_reg;
        ys_next    = ys_reg;
        dec_next   = dec_reg;
        diag_next  = diag_reg;
        fin_next   = fin_reg;
        alu_ctl    = '0;
        mul_a      = '0;
        mul_b      = '0;
        opa        = '0;
        opb        = '0;
        emit_load  = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (!s_operation) begin
                        cx_next    = s_center_x;
                        cy_next    = s_center_y;
                        rx_next    = s_radius_x;
                        ry_next    = s_radius_y;
                        x_next     = '0;
                        y_next     = s_radius_y;
                        xs_next    = '0;
                        fin_next   = 1'b0;
                        phase_next = PH_REG1;
                        state_next = S_SQ_RX;
                    end else if (in_reg1) begin
                        diag_next  = !dec_reg[DEC_W-1];
                        state_next = S_ST_X;
                    end else if (in_reg2) begin
                        diag_next  = dec_reg[DEC_W-1] || (dec_reg == '0);
                        state_next = S_ST_X;
                    end
                end
            end
            S_SQ_RX: begin
                alu_ctl.mul_en = 1'b1;
                mul_a          = MUL_W'(rx_reg);
                mul_b          = MUL_W'(rx_reg);
                state_next     = S_SQ_RY;
            end
            S_SQ_RY: begin
                rx_sq_next     = prod[SQ_W-1:0];
                alu_ctl.mul_en = 1'b1;
                mul_a          = MUL_W'(ry_reg);
                mul_b          = MUL_W'(ry_reg);
                state_next     = S_RXRY;
            end
            S_RXRY: begin
                ry_sq_next     = prod[SQ_W-1:0];
                alu_ctl.mul_en = 1'b1;
                mul_a          = MUL_W'(rx_sq_reg);
                mul_b          = MUL_W'(ry_reg);
                state_next     = S_YS;
            end
            S_YS: begin
                // prod = rx^2 * ry
                ys_next     = {prod[SLOPE_W-2:0], 1'b0};
                alu_ctl.sub = 1'b1;
                opa         = DEC_W'(ry_sq_reg) << 2;
                opb         = DEC_W'(prod) << 2;
                dec_next    = sum;
                state_next  = S_DEC0;
            end
            S_DEC0: begin
                opa        = dec_reg;
                opb        = DEC_W'(rx_sq_reg);
                dec_next   = sum;
                state_next = S_QTR;
            end
            S_QTR: begin
                opa        = dec_reg >>> 2;
                opb        = DEC_W'(qtr_round);
                dec_next   = sum;
                state_next = S_SETTLE;
            end
            S_SETTLE: begin
                if (in_reg1 && (xs_reg >= ys_reg)) begin
                    phase_next = PH_REG2;
                    state_next = S_RC0;
                end else if (in_reg2 && (y_reg == '0)) begin
                    phase_next = PH_DONE;
                    fin_next   = 1'b1;
                    state_next = S_EMIT;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_RC0: begin
                alu_ctl.mul_en = 1'b1;
                mul_a          = MUL_W'(ry_reg);
                mul_b          = MUL_W'({x_reg, 1'b1});
                state_next     = S_RC1;
            end
            S_RC1: begin
                alu_ctl.mul_en = 1'b1;
                mul_a          = prod[MUL_W-1:0];
                mul_b          = prod[MUL_W-1:0];
                state_next     = S_RC2;
            end
            S_RC2: begin
                // ry^2 * (2x+1)^2
                opb            = DEC_W'(prod);
                dec_next       = sum;
                alu_ctl.mul_en = 1'b1;
                mul_a          = MUL_W'(rx_reg);
                mul_b          = MUL_W'(ty_abs);
                state_next     = S_RC3;
            end
            S_RC3: begin
                alu_ctl.mul_en = 1'b1;
                mul_a          = prod[MUL_W-1:0];
                mul_b          = prod[MUL_W-1:0];
                state_next     = S_RC4;
            end
            S_RC4: begin
                // + 4 * rx^2 * (y-1)^2
                opa            = dec_reg;
                opb            = DEC_W'(prod) << 2;
                dec_next       = sum;
                alu_ctl.mul_en = 1'b1;
                mul_a          = MUL_W'(rx_reg);
                mul_b          = MUL_W'(ry_reg);
                state_next     = S_RC5;
            end
            S_RC5: begin
                alu_ctl.mul_en = 1'b1;
                mul_a          = prod[MUL_W-1:0];
                mul_b          = prod[MUL_W-1:0];
                state_next     = S_RC6;
            end
            S_RC6: begin
                // - 4 * rx^2 * ry^2
                alu_ctl.sub = 1'b1;
                opa         = dec_reg;
                opb         = DEC_W'(prod) << 2;
                dec_next    = sum;
                state_next  = S_QTR;
            end
            S_ST_X: begin
                if (move_x) begin
                    opa     = DEC_W'(xs_reg);
                    opb     = DEC_W'(ry_sq_reg) << 1;
                    xs_next = sum[SLOPE_W-1:0];
                    x_next  = x_reg + OFS_W'(1);
                end
                state_next = S_ST_Y;
            end
            S_ST_Y: begin
                if (move_y) begin
                    alu_ctl.sub = 1'b1;
                    opa         = DEC_W'(ys_reg);
                    opb         = DEC_W'(rx_sq_reg) << 1;
                    ys_next     = sum[SLOPE_W-1:0];
                    y_next      = y_reg - RADIUS_BITS'(1);
                end
                state_next = S_ST_DA;
            end
            S_ST_DA: begin
                opa        = dec_reg;
                opb        = in_reg1 ? DEC_W'(ry_sq_reg) : DEC_W'(rx_sq_reg);
                dec_next   = sum;
                state_next = S_ST_DX;
            end
            S_ST_DX: begin
                if (move_x) begin
                    opa      = dec_reg;
                    opb      = DEC_W'(xs_reg);
                    dec_next = sum;
                end
                state_next = S_ST_DY;
            end
            S_ST_DY: begin
                if (move_y) begin
                    alu_ctl.sub = 1'b1;
                    opa         = dec_reg;
                    opb         = DEC_W'(ys_reg);
                    dec_next    = sum;
                end
                state_next = S_SETTLE;
            end
            S_EMIT: begin
                // Hand the group over once the emitter is empty
                if (!emit_busy) begin
                    emit_load  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= PH_IDLE;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    // Ellipse working registers
    always_ff @(posedge aclk) begin
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        rx_reg    <= rx_next;
        ry_reg    <= ry_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        rx_sq_reg <= rx_sq_next;
        ry_sq_reg <= ry_sq_next;
        xs_reg    <= xs_next;
        ys_reg    <= ys_next;
        dec_reg   <= dec_next;
        diag_reg  <= diag_next;
        fin_reg   <= fin_next;
    end

    mpe_alu #(
        .MUL_W (MUL_W),
        .DEC_W (DEC_W)
    ) u_alu (
        .aclk  (aclk),
        .ctl   (alu_ctl),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .opa   (opa),
        .opb   (opb),
        .prod  (prod),
        .sum   (sum)
    );

    mpe_emit #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_emit (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (emit_load),
        .busy            (emit_busy),
        .center_x        (cx_reg),
        .center_y        (cy_reg),
        .ofs_x           (x_reg),
        .ofs_y           (y_reg),
        .fin             (fin_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_x       (m_pixel_x),
        .m_pixel_y       (m_pixel_y),
        .m_last_of_group (m_last_of_group),
        .m_finished      (m_finished)
    );

endmodule

### rtl/mpe_alu.sv
// ----------------------------------------------------------------------------
// Shared arithmetic unit
// One registered multiplier and one wide adder/subtractor, reused by the
// sequencer for every squared term, slope update and decision update.
// ----------------------------------------------------------------------------
module mpe_alu #(
    parameter int MUL_W = 22,
    parameter int DEC_W = 48
) (
    input  logic                          aclk,
    input  mpe_pkg::alu_ctl_t             ctl,
    input  logic [MUL_W-1:0]              mul_a,
    input  logic [MUL_W-1:0]              mul_b,
    input  logic signed [DEC_W-1:0]       opa,
    input  logic signed [DEC_W-1:0]       opb,
    output logic [2*MUL_W-1:0]            prod,
    output logic signed [DEC_W-1:0]       sum
);
    import mpe_pkg::*;

    localparam int PROD_W = 2 * MUL_W;

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    // Multiply; the product is registered and available in the cycle after issue
    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

    // Add or subtract
    assign sum = ctl.sub ? (opa - opb) : (opa + opb);

endmodule

### rtl/mpe_emit.sv
// ----------------------------------------------------------------------------
// Mirrored point emitter
// Holds one offset pair and the centre, and sends the four mirrored points
// in the order (+x,+y), (-x,+y), (+x,-y), (-x,-y) over the result channel.
// ----------------------------------------------------------------------------
module mpe_emit #(
    parameter int COORD_BITS  = 11,
    parameter int RADIUS_BITS = 10
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               load,
    output logic                               busy,
    input  logic [COORD_BITS-1:0]              center_x,
    input  logic [COORD_BITS-1:0]              center_y,
    input  logic [RADIUS_BITS:0]               ofs_x,
    input  logic [RADIUS_BITS-1:0]             ofs_y,
    input  logic                               fin,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [mpe_pkg::PIX_W-1:0]   m_pixel_x,
    output logic signed [mpe_pkg::PIX_W-1:0]   m_pixel_y,
    output logic                               m_last_of_group,
    output logic                               m_finished
);
    import mpe_pkg::*;

    localparam int SUM_W = COORD_BITS + PIX_W;

    logic                   valid_reg, valid_next;
    logic [1:0]             idx_reg, idx_next;
    logic [COORD_BITS-1:0]  cx_reg, cy_reg;
    logic [RADIUS_BITS:0]   ox_reg;
    logic [RADIUS_BITS-1:0] oy_reg;
    logic                   fin_reg;
    logic [SUM_W-1:0]       px_sum, py_sum;

    // Advance through the four points, reload when empty
    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (valid_reg && m_ready) begin
            if (idx_reg == 2'd3) begin
                valid_next = 1'b0;
            end
            idx_next = idx_reg + 2'd1;
        end
        if (load && !valid_reg) begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Hold the point data of the current group
    always_ff @(posedge aclk) begin
        if (load && !valid_reg) begin
            cx_reg  <= center_x;
            cy_reg  <= center_y;
            ox_reg  <= ofs_x;
            oy_reg  <= ofs_y;
            fin_reg <= fin;
        end
    end

    // Mirror: bit 0 of the index negates x, bit 1 negates y
    assign px_sum = idx_reg[0] ? (SUM_W'(cx_reg) - SUM_W'(ox_reg))
                               : (SUM_W'(cx_reg) + SUM_W'(ox_reg));
    assign py_sum = idx_reg[1] ? (SUM_W'(cy_reg) - SUM_W'(oy_reg))
                               : (SUM_W'(cy_reg) + SUM_W'(oy_reg));

    assign busy            = valid_reg;
    assign m_valid         = valid_reg;
    assign m_pixel_x       = px_sum[PIX_W-1:0];
    assign m_pixel_y       = py_sum[PIX_W-1:0];
    assign m_last_of_group = (idx_reg == 2'd3);
    assign m_finished      = fin_reg;

endmodule

### rtl/mpe_checker.sv
// ----------------------------------------------------------------------------
// Midpoint ellipse port checker
// Watches the top-level ports for group framing and output behavior.
// ----------------------------------------------------------------------------
module mpe_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic                               s_operation,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic signed [mpe_pkg::PIX_W-1:0]   m_pixel_x,
    input  logic signed [mpe_pkg::PIX_W-1:0]   m_pixel_y,
    input  logic                               m_last_of_group,
    input  logic                               m_finished
);
    import mpe_pkg::*;

    logic [1:0]             grp_cnt_reg, grp_cnt_next;
    logic                   fin_reg, fin_next;
    logic                   m_xfer;

    assign m_xfer = m_valid && m_ready;

    // Track position within a group and the done flag
    always_comb begin
        grp_cnt_next = grp_cnt_reg;
        fin_next     = fin_reg;
        if (m_xfer) begin
            grp_cnt_next = grp_cnt_reg + 2'd1;
            if (grp_cnt_reg == 2'd0) begin
                fin_next = m_finished;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_cnt_reg <= 2'd0;
        end else begin
            grp_cnt_reg <= grp_cnt_next;
        end
        fin_reg <= fin_next;
    end

    // Reset empties the result channel
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_x) && $stable(m_pixel_y)
            && $stable(m_last_of_group) && $stable(m_finished))
        else $error("stalled result changed");

    // Last flag marks exactly the fourth transaction of a group
    a_last_position: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_of_group == (grp_cnt_reg == 2'd3)))
        else $error("last_of_group out of place");

    // Finished flag is constant across a group
    a_fin_group: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (grp_cnt_reg != 2'd0) |-> (m_finished == fin_reg))
        else $error("finished flag changed inside a group");

    // A start transaction always occupies the sequencer
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_operation |=> !s_ready)
        else $error("ready stayed high after a start");

endmodule

bind midpoint_ellipse_point_generator mpe_checker u_mpe_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_operation     (s_operation),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_pixel_x       (m_pixel_x),
    .m_pixel_y       (m_pixel_y),
    .m_last_of_group (m_last_of_group),
    .m_finished      (m_finished)
);
